// ----- hdl/nnrr_pkg.sv -----
`timescale 1ns / 1ps
package nnrr_pkg;

    localparam int UNIT_BITS_DEF  = 32;
    localparam int DIM_BITS_DEF   = 16;
    localparam int MAX_REPEAT_DEF = 64;

    // copy queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_IN_ROWS  = 2'd0,
        REG_IN_COLS  = 2'd1,
        REG_OUT_ROWS = 2'd2,
        REG_OUT_COLS = 2'd3
    } t_reg_idx;

    typedef enum logic {
        FE_IDLE,
        FE_WALK
    } t_fe_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

// ----- hdl/nnrr_div.sv -----
`timescale 1ns / 1ps
module nnrr_div #(
    parameter int DIM_BITS = nnrr_pkg::DIM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIM_BITS-1:0] i_num,
    input  logic [DIM_BITS-1:0] i_den,
    output logic                o_busy,
    output logic [DIM_BITS-1:0] o_quot,
    output logic [DIM_BITS-1:0] o_rem
);
    import nnrr_pkg::*;

    localparam int CNT_BITS = $clog2(DIM_BITS + 1);

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIM_BITS-1:0] r_quot;
    logic [DIM_BITS:0]   r_rem;
    logic [DIM_BITS-1:0] r_den;

    logic [DIM_BITS-1:0] n_quot;
    logic [DIM_BITS:0]   n_rem;
    logic [DIM_BITS:0]   shifted;
    logic                fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem[DIM_BITS-1:0], r_quot[DIM_BITS-1]};
        fits    = shifted >= {1'b0, r_den};
        n_quot  = {r_quot[DIM_BITS-2:0], fits};
        n_rem   = fits ? (shifted - {1'b0, r_den}) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(DIM_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DIM_BITS-1:0];

endmodule

// ----- hdl/nnrr_fifo.sv -----
`timescale 1ns / 1ps
module nnrr_fifo #(
    parameter int WIDTH = nnrr_pkg::UNIT_BITS_DEF + 2,
    parameter int DEPTH = nnrr_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output nnrr_pkg::t_q_flags  o_flags
);
    import nnrr_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;
    logic                wr_en;
    logic                rd_en;

    always_comb begin
        o_flags.full  = r_count == CNT_BITS'(DEPTH);
        o_flags.empty = r_count == '0;
        wr_en = i_push && !o_flags.full;
        rd_en = i_pop && !o_flags.empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

// ----- hdl/nnrr_front.sv -----
`timescale 1ns / 1ps
module nnrr_front #(
    parameter int UNIT_BITS  = nnrr_pkg::UNIT_BITS_DEF,
    parameter int DIM_BITS   = nnrr_pkg::DIM_BITS_DEF,
    parameter int MAX_REPEAT = nnrr_pkg::MAX_REPEAT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_steps_ok,
    input  logic                 i_restart,
    input  logic                 i_push,
    input  logic [UNIT_BITS-1:0] i_sample,
    output logic                 o_full,
    input  logic [DIM_BITS-1:0]  i_in_rows,
    input  logic [DIM_BITS-1:0]  i_in_cols,
    input  logic [DIM_BITS-1:0]  i_out_rows,
    input  logic [DIM_BITS-1:0]  i_out_cols,
    input  logic [DIM_BITS-1:0]  i_row_quot,
    input  logic [DIM_BITS-1:0]  i_row_rem,
    input  logic [DIM_BITS-1:0]  i_col_quot,
    input  logic [DIM_BITS-1:0]  i_col_rem,
    input  nnrr_pkg::t_q_flags   i_q_flags,
    output logic                 o_q_push,
    output logic [UNIT_BITS+1:0] o_q_data
);
    import nnrr_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_REPEAT + 1);

    t_fe_state           r_state, n_state;
    logic [UNIT_BITS-1:0] r_samp, n_samp;
    logic [DIM_BITS-1:0] r_src_row, n_src_row;
    logic [DIM_BITS-1:0] r_src_col, n_src_col;
    logic [DIM_BITS-1:0] r_dst_row, n_dst_row;
    logic [DIM_BITS-1:0] r_dst_col, n_dst_col;
    logic [DIM_BITS-1:0] r_want_row, n_want_row;
    logic [DIM_BITS-1:0] r_want_col, n_want_col;
    logic [DIM_BITS-1:0] r_rem_row, n_rem_row;
    logic [DIM_BITS-1:0] r_rem_col, n_rem_col;
    logic                r_done, n_done;
    logic                r_ended, n_ended;
    logic                r_pend, n_pend;
    logic [CNT_BITS-1:0] r_n, n_n;

    logic                accept;
    logic                match;
    logic                emit;
    logic                want_push;
    logic                stall;
    logic [DIM_BITS:0]   col_sum;
    logic [DIM_BITS:0]   row_sum;
    logic                col_carry;
    logic                row_carry;
    logic [DIM_BITS-1:0] step_rem_col;
    logic [DIM_BITS-1:0] step_rem_row;
    logic [DIM_BITS-1:0] step_want_col;
    logic [DIM_BITS-1:0] step_want_row;
    logic                dst_col_end;
    logic                dst_row_end;
    logic                src_col_end;
    logic                src_row_end;

    // wanted position kept as quotient and remainder of dst * in / out,
    // stepped by the precomputed in / out
    always_comb begin
        col_sum       = {1'b0, r_rem_col} + {1'b0, i_col_rem};
        col_carry     = col_sum >= {1'b0, i_out_cols};
        step_rem_col  = col_carry ? DIM_BITS'(col_sum - {1'b0, i_out_cols})
                                  : DIM_BITS'(col_sum);
        step_want_col = r_want_col + i_col_quot + DIM_BITS'(col_carry);
        row_sum       = {1'b0, r_rem_row} + {1'b0, i_row_rem};
        row_carry     = row_sum >= {1'b0, i_out_rows};
        step_rem_row  = row_carry ? DIM_BITS'(row_sum - {1'b0, i_out_rows})
                                  : DIM_BITS'(row_sum);
        step_want_row = r_want_row + i_row_quot + DIM_BITS'(row_carry);
        dst_col_end   = ({1'b0, r_dst_col} + 1'b1) >= {1'b0, i_out_cols};
        dst_row_end   = ({1'b0, r_dst_row} + 1'b1) >= {1'b0, i_out_rows};
        src_col_end   = ({1'b0, r_src_col} + 1'b1) >= {1'b0, i_in_cols};
        src_row_end   = ({1'b0, r_src_row} + 1'b1) >= {1'b0, i_in_rows};
    end

    assign o_full = (r_state != FE_IDLE) || !i_steps_ok;
    assign accept = i_push && !o_full;
    assign match  = !r_done && (r_want_row == r_src_row) && (r_want_col == r_src_col);
    assign emit   = r_n < CNT_BITS'(MAX_REPEAT);

    always_comb begin
        n_state    = r_state;
        n_samp     = r_samp;
        n_src_row  = r_src_row;
        n_src_col  = r_src_col;
        n_dst_row  = r_dst_row;
        n_dst_col  = r_dst_col;
        n_want_row = r_want_row;
        n_want_col = r_want_col;
        n_rem_row  = r_rem_row;
        n_rem_col  = r_rem_col;
        n_done     = r_done;
        n_ended    = r_ended;
        n_pend     = r_pend;
        n_n        = r_n;
        want_push  = 1'b0;
        o_q_data   = {r_samp, 1'b0, 1'b0};

        case (r_state)
            FE_IDLE: begin
                if (accept) begin
                    n_samp  = i_sample;
                    n_n     = '0;
                    n_ended = 1'b0;
                    n_pend  = 1'b0;
                    n_state = FE_WALK;
                end
            end
            FE_WALK: begin
                if (match) begin
                    // the newest copy stays pending until we know if it is the last
                    want_push = emit && r_pend;
                    if (!(want_push && i_q_flags.full)) begin
                        if (emit) begin
                            n_pend = 1'b1;
                            n_n    = r_n + 1'b1;
                        end
                        if (dst_col_end) begin
                            n_dst_col  = '0;
                            n_want_col = '0;
                            n_rem_col  = '0;
                            if (dst_row_end) begin
                                n_dst_row  = '0;
                                n_want_row = '0;
                                n_rem_row  = '0;
                                n_done     = 1'b1;
                                n_ended    = 1'b1;
                            end else begin
                                n_dst_row  = r_dst_row + 1'b1;
                                n_want_row = step_want_row;
                                n_rem_row  = step_rem_row;
                            end
                        end else begin
                            n_dst_col  = r_dst_col + 1'b1;
                            n_want_col = step_want_col;
                            n_rem_col  = step_rem_col;
                        end
                    end
                end else begin
                    want_push = r_pend;
                    o_q_data  = {r_samp, 1'b1, r_ended};
                    if (!(want_push && i_q_flags.full)) begin
                        n_pend  = 1'b0;
                        n_state = FE_IDLE;
                        if (src_col_end) begin
                            n_src_col = '0;
                            if (src_row_end) begin
                                // input frame complete: start over
                                n_src_row  = '0;
                                n_dst_row  = '0;
                                n_dst_col  = '0;
                                n_want_row = '0;
                                n_want_col = '0;
                                n_rem_row  = '0;
                                n_rem_col  = '0;
                                n_done     = 1'b0;
                            end else begin
                                n_src_row = r_src_row + 1'b1;
                            end
                        end else begin
                            n_src_col = r_src_col + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = FE_IDLE;
            end
        endcase

        if (i_restart) begin
            n_state    = FE_IDLE;
            n_pend     = 1'b0;
            n_src_row  = '0;
            n_src_col  = '0;
            n_dst_row  = '0;
            n_dst_col  = '0;
            n_want_row = '0;
            n_want_col = '0;
            n_rem_row  = '0;
            n_rem_col  = '0;
            n_done     = 1'b0;
        end
    end

    assign stall    = want_push && i_q_flags.full;
    assign o_q_push = want_push && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FE_IDLE;
            r_src_row  <= '0;
            r_src_col  <= '0;
            r_dst_row  <= '0;
            r_dst_col  <= '0;
            r_want_row <= '0;
            r_want_col <= '0;
            r_rem_row  <= '0;
            r_rem_col  <= '0;
            r_done     <= 1'b0;
            r_ended    <= 1'b0;
            r_pend     <= 1'b0;
            r_n        <= '0;
        end else begin
            r_state    <= n_state;
            r_src_row  <= n_src_row;
            r_src_col  <= n_src_col;
            r_dst_row  <= n_dst_row;
            r_dst_col  <= n_dst_col;
            r_want_row <= n_want_row;
            r_want_col <= n_want_col;
            r_rem_row  <= n_rem_row;
            r_rem_col  <= n_rem_col;
            r_done     <= n_done;
            r_ended    <= n_ended;
            r_pend     <= n_pend;
            r_n        <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_samp <= n_samp;
    end

endmodule

// ----- hdl/nnrr_back.sv -----
`timescale 1ns / 1ps
module nnrr_back #(
    parameter int WIDTH = nnrr_pkg::UNIT_BITS_DEF + 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [WIDTH-1:0]   i_q_data,
    input  nnrr_pkg::t_q_flags i_q_flags,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [WIDTH-1:0]   o_data
);
    import nnrr_pkg::*;

    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_data;

    // output register refills from the queue as the held result leaves
    always_comb begin
        o_q_pop = !i_q_flags.empty && (!r_valid || i_pop);
        n_valid = r_valid;
        if (o_q_pop) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

    assign o_empty = !r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/nearest_neighbor_raster_resampler.sv -----
// Nearest-neighbor raster resampler.
// Input queue side: push / full, one sample per request, in row-major order.
// Result queue side: empty / pop; each request carries a sample copy, last_copy
// on the final copy for its input, and frame_end on the copy that ends the frame.
// Registers on the APB-style port (byte addresses 0x0, 0x4, 0x8, 0xC): in_rows,
// in_cols, out_rows, out_cols. Any write restarts the frame.
// The front takes one input at a time and walks the output points it covers
// (copies plus points skipped past the 64-copy cap), one output point per cycle
// while the copy queue has room. Each copy reaches the result ports through the
// copy queue and the output register of the back.
// After reset and after each register write, full stays high while the row and
// column step sizes are divided out.
// A stalled result side fills the 4-entry copy queue, then the front holds and
// full stays high; nothing is dropped.
`timescale 1ns / 1ps
module nearest_neighbor_raster_resampler #(
    parameter int UNIT_BITS  = nnrr_pkg::UNIT_BITS_DEF,
    parameter int DIM_BITS   = nnrr_pkg::DIM_BITS_DEF,
    parameter int MAX_REPEAT = nnrr_pkg::MAX_REPEAT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nnrr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [nnrr_pkg::DATA_BITS-1:0] pwdata,
    output logic [nnrr_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  logic [UNIT_BITS-1:0]           i_sample,
    output logic                           empty,
    input  logic                           pop,
    output logic [UNIT_BITS-1:0]           o_sample_out,
    output logic                           o_last_copy,
    output logic                           o_frame_end
);
    import nnrr_pkg::*;

    localparam int Q_WIDTH = UNIT_BITS + 2;

    logic [DIM_BITS-1:0] r_in_rows;
    logic [DIM_BITS-1:0] r_in_cols;
    logic [DIM_BITS-1:0] r_out_rows;
    logic [DIM_BITS-1:0] r_out_cols;
    logic                r_div_go;

    logic                cfg_wr;
    t_reg_idx            cfg_idx;
    logic [DIM_BITS-1:0] eff_in_rows;
    logic [DIM_BITS-1:0] eff_in_cols;
    logic [DIM_BITS-1:0] eff_out_rows;
    logic [DIM_BITS-1:0] eff_out_cols;
    logic [DIM_BITS-1:0] out_rows_nz;
    logic                row_busy;
    logic                col_busy;
    logic [DIM_BITS-1:0] row_quot;
    logic [DIM_BITS-1:0] row_rem;
    logic [DIM_BITS-1:0] col_quot;
    logic [DIM_BITS-1:0] col_rem;
    logic                steps_ok;

    logic                q_push;
    logic [Q_WIDTH-1:0]  q_in_data;
    logic                q_pop;
    logic [Q_WIDTH-1:0]  q_out_data;
    t_q_flags            q_flags;
    logic [Q_WIDTH-1:0]  res_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rows  <= DIM_BITS'(1);
            r_in_cols  <= DIM_BITS'(1);
            r_out_rows <= DIM_BITS'(1);
            r_out_cols <= DIM_BITS'(1);
            r_div_go   <= 1'b1;
        end else begin
            r_div_go <= cfg_wr;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_IN_ROWS:  r_in_rows  <= DIM_BITS'(pwdata);
                    REG_IN_COLS:  r_in_cols  <= DIM_BITS'(pwdata);
                    REG_OUT_ROWS: r_out_rows <= DIM_BITS'(pwdata);
                    REG_OUT_COLS: r_out_cols <= DIM_BITS'(pwdata);
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IN_ROWS:  prdata = DATA_BITS'(r_in_rows);
            REG_IN_COLS:  prdata = DATA_BITS'(r_in_cols);
            REG_OUT_ROWS: prdata = DATA_BITS'(r_out_rows);
            REG_OUT_COLS: prdata = DATA_BITS'(r_out_cols);
            default:      prdata = '0;
        endcase
    end

    // zero acts as one; output rows never exceed input rows
    always_comb begin
        eff_in_rows  = (r_in_rows == '0) ? DIM_BITS'(1) : r_in_rows;
        eff_in_cols  = (r_in_cols == '0) ? DIM_BITS'(1) : r_in_cols;
        eff_out_cols = (r_out_cols == '0) ? DIM_BITS'(1) : r_out_cols;
        out_rows_nz  = (r_out_rows == '0) ? DIM_BITS'(1) : r_out_rows;
        eff_out_rows = (out_rows_nz > eff_in_rows) ? eff_in_rows : out_rows_nz;
    end

    nnrr_div #(
        .DIM_BITS (DIM_BITS)
    ) u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (eff_in_rows),
        .i_den   (eff_out_rows),
        .o_busy  (row_busy),
        .o_quot  (row_quot),
        .o_rem   (row_rem)
    );

    nnrr_div #(
        .DIM_BITS (DIM_BITS)
    ) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (eff_in_cols),
        .i_den   (eff_out_cols),
        .o_busy  (col_busy),
        .o_quot  (col_quot),
        .o_rem   (col_rem)
    );

    assign steps_ok = !r_div_go && !row_busy && !col_busy;

    nnrr_front #(
        .UNIT_BITS  (UNIT_BITS),
        .DIM_BITS   (DIM_BITS),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_steps_ok (steps_ok),
        .i_restart  (cfg_wr),
        .i_push     (push),
        .i_sample   (i_sample),
        .o_full     (full),
        .i_in_rows  (eff_in_rows),
        .i_in_cols  (eff_in_cols),
        .i_out_rows (eff_out_rows),
        .i_out_cols (eff_out_cols),
        .i_row_quot (row_quot),
        .i_row_rem  (row_rem),
        .i_col_quot (col_quot),
        .i_col_rem  (col_rem),
        .i_q_flags  (q_flags),
        .o_q_push   (q_push),
        .o_q_data   (q_in_data)
    );

    nnrr_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_flags (q_flags)
    );

    nnrr_back #(
        .WIDTH (Q_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_out_data),
        .i_q_flags (q_flags),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_data    (res_data)
    );

    assign o_sample_out = res_data[Q_WIDTH-1:2];
    assign o_last_copy  = res_data[1];
    assign o_frame_end  = res_data[0];

endmodule

// ----- hdl/nnrr_chk.sv -----
`timescale 1ns / 1ps
module nnrr_chk #(
    parameter int UNIT_BITS = nnrr_pkg::UNIT_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [UNIT_BITS-1:0] o_sample_out,
    input logic                 o_last_copy,
    input logic                 o_frame_end
);

    // a waiting result holds until it is taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample_out)
                              && $stable(o_last_copy) && $stable(o_frame_end)))
        else $error("result changed while stalled");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> o_last_copy)
        else $error("frame_end without last_copy");

    // one input at a time: the front is busy right after it takes one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("input accepted on consecutive cycles");

    // step sizes are recomputed after every register write
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> full)
        else $error("input side open right after a register write");

endmodule

bind nearest_neighbor_raster_resampler nnrr_chk #(
    .UNIT_BITS (UNIT_BITS)
) u_nnrr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_sample_out (o_sample_out),
    .o_last_copy  (o_last_copy),
    .o_frame_end  (o_frame_end)
);

// ----- dv/nearest_neighbor_raster_resampler_tb.sv -----
`timescale 1ns / 1ps
module nearest_neighbor_raster_resampler_tb;
    import nnrr_pkg::*;

    localparam int UNIT_W       = 32;
    localparam int DIM_W        = 16;
    localparam int MAX_COPIES   = 64;
    localparam int SETTLE_CYC   = 256;
    localparam int HOLD_CYC     = 300;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 110;

    typedef struct packed {
        logic [UNIT_W-1:0] smp;
        logic              last_copy;
        logic              frame_end;
    } t_copy;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 push = 1'b0;
    logic                 full;
    logic [UNIT_W-1:0]    i_sample = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [UNIT_W-1:0]    o_sample_out;
    logic                 o_last_copy;
    logic                 o_frame_end;

    nearest_neighbor_raster_resampler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_sample     (i_sample),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out),
        .o_last_copy  (o_last_copy),
        .o_frame_end  (o_frame_end)
    );

    always #1 i_clk = ~i_clk;

    // resampler shadow: geometry and raster position
    logic [DIM_W-1:0] in_rows_q, in_cols_q, out_rows_q, out_cols_q;
    logic [31:0]      src_r, src_c, dst_r, dst_c, want_r, want_c;
    bit               frame_closed;

    t_copy            copies_due[$];
    logic [UNIT_W-1:0] sample_fifo[$];
    int               queued_cnt = 0;
    int               taken_cnt = 0;
    int               err_cnt = 0;
    int               cycle_cnt = 0;
    int               idle_mode = 0;
    bit               hold_go = 1'b0;
    bit               hold_done = 1'b0;
    int               hold_cnt = 0;
    bit               push_took = 1'b0;

    function automatic logic [31:0] nz(logic [DIM_W-1:0] v);
        return (v == '0) ? 32'd1 : {16'd0, v};
    endfunction

    function automatic logic [31:0] rows_out_eff();
        logic [31:0] r;
        logic [31:0] lim;
        r   = nz(out_rows_q);
        lim = nz(in_rows_q);
        return (r > lim) ? lim : r;
    endfunction

    function automatic void aim_point();
        want_r = (dst_r * nz(in_rows_q)) / rows_out_eff();
        want_c = (dst_c * nz(in_cols_q)) / nz(out_cols_q);
    endfunction

    function automatic void rewind_raster();
        src_r = 0;
        src_c = 0;
        dst_r = 0;
        dst_c = 0;
        frame_closed = 1'b0;
        aim_point();
    endfunction

    function automatic void next_point();
        dst_c++;
        if (dst_c >= nz(out_cols_q)) begin
            dst_c = 0;
            dst_r++;
            if (dst_r >= rows_out_eff()) begin
                dst_r = 0;
                frame_closed = 1'b1;
            end
        end
        aim_point();
    endfunction

    function automatic void apply_reg(t_reg_idx idx, logic [DIM_W-1:0] val);
        case (idx)
            REG_IN_ROWS:  in_rows_q = val;
            REG_IN_COLS:  in_cols_q = val;
            REG_OUT_ROWS: out_rows_q = val;
            REG_OUT_COLS: out_cols_q = val;
            default: ;
        endcase
        rewind_raster();
    endfunction

    function automatic void resample_sample(logic [UNIT_W-1:0] s);
        t_copy burst[$];
        t_copy c;
        bit    ended;
        ended = 1'b0;
        while (!frame_closed && want_r == src_r && want_c == src_c) begin
            if (burst.size() < MAX_COPIES) begin
                c.smp       = s;
                c.last_copy = 1'b0;
                c.frame_end = 1'b0;
                burst.push_back(c);
            end
            next_point();
            if (frame_closed)
                ended = 1'b1;
        end
        if (burst.size() > 0) begin
            burst[$].last_copy = 1'b1;
            burst[$].frame_end = ended;
        end
        foreach (burst[k])
            copies_due.push_back(burst[k]);
        src_c++;
        if (src_c >= nz(in_cols_q)) begin
            src_c = 0;
            src_r++;
            if (src_r >= nz(in_rows_q))
                rewind_raster();
        end
    endfunction

    function automatic int send_idle_pct();
        return (idle_mode == 0) ? 16 : (idle_mode == 1) ? 52 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (idle_mode == 0) ? 52 : (idle_mode == 1) ? 16 : 0;
    endfunction

    // sender: an offered request stays up until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && !push_took)) begin
            if (sample_fifo.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                push     <= 1'b1;
                i_sample <= sample_fifo[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        push_took <= push && !full;
        if (i_rst_n && push && !full) begin
            resample_sample(i_sample);
            void'(sample_fifo.pop_front());
            taken_cnt++;
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cnt > 0) begin
            pop      <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_go && !hold_done) begin
            pop       <= 1'b0;
            hold_cnt  <= HOLD_CYC;
            hold_done <= 1'b1;
        end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        t_copy want;
        if (i_rst_n && pop && !empty) begin
            if (copies_due.size() == 0) begin
                $display("%0t: unexpected copy sample=%h last=%b end=%b",
                         $time, o_sample_out, o_last_copy, o_frame_end);
                err_cnt++;
            end else begin
                want = copies_due.pop_front();
                if (o_sample_out !== want.smp) begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, want.smp, o_sample_out);
                    err_cnt++;
                end
                if (o_last_copy !== want.last_copy) begin
                    $display("%0t: last_copy expected %b actual %b",
                             $time, want.last_copy, o_last_copy);
                    err_cnt++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b",
                             $time, want.frame_end, o_frame_end);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [DIM_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic reg_read_check(t_reg_idx idx, logic [DIM_W-1:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[DIM_W-1:0] !== want) begin
            $display("%0t: readback %s expected %h actual %h",
                     $time, idx.name(), want, prdata[DIM_W-1:0]);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // all requests taken, all copies out, then let the front settle
    task automatic drain();
        while (taken_cnt != queued_cnt || copies_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic setup(int ir, int ic, int orw, int oc);
        drain();
        reg_write(REG_IN_ROWS, DIM_W'(ir));
        reg_write(REG_IN_COLS, DIM_W'(ic));
        reg_write(REG_OUT_ROWS, DIM_W'(orw));
        reg_write(REG_OUT_COLS, DIM_W'(oc));
        reg_read_check(REG_IN_ROWS, DIM_W'(ir));
        reg_read_check(REG_IN_COLS, DIM_W'(ic));
        reg_read_check(REG_OUT_ROWS, DIM_W'(orw));
        reg_read_check(REG_OUT_COLS, DIM_W'(oc));
    endtask

    task automatic feed_one(logic [UNIT_W-1:0] s);
        sample_fifo.push_back(s);
        queued_cnt++;
    endtask

    task automatic feed(int n);
        repeat (n) feed_one($urandom);
    endtask

    initial begin
        int rnd_items;
        int n;
        in_rows_q  = 1;
        in_cols_q  = 1;
        out_rows_q = 1;
        out_cols_q = 1;
        rewind_raster();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry: one copy per input, each closing the frame
        feed_one('0);
        feed_one('1);
        // zero registers behave as one
        setup(0, 0, 0, 0);
        feed(2);
        // rows clamp to input rows, columns upsample, frame wraps
        setup(3, 4, 5, 7);
        feed(14);
        // copy cap, with and without frame end on the capped input
        setup(2, 1, 2, 100);
        feed(2);
        setup(65535, 65535, 65535, 65535);
        feed(2);
        // widest column upsample; second row is dropped
        setup(2, 1, 1, 65535);
        feed(2);
        setup(1, 65535, 1, 1);
        feed(2);

        // long receiver stall while every input yields copies
        setup(4, 4, 4, 8);
        hold_go = 1'b1;
        feed(24);
        // count covers every item sent so far
        rnd_items = 50;
        while (rnd_items < RANDOM_ITEMS) begin
            n = $urandom_range(8, 24);
            if (n > RANDOM_ITEMS - rnd_items)
                n = RANDOM_ITEMS - rnd_items;
            if ($urandom_range(0, 7) == 0)
                setup($urandom_range(0, 4), $urandom_range(1, 3),
                      $urandom_range(0, 4), $urandom_range(100, 200));
            else
                setup($urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 10), $urandom_range(0, 10));
            idle_mode = (rnd_items < RANDOM_ITEMS / 3) ? 0 :
                        (rnd_items < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            feed(n);
            rnd_items += n;
        end

        drain();
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/nnrr_pkg.sv
hdl/nnrr_div.sv
hdl/nnrr_fifo.sv
hdl/nnrr_front.sv
hdl/nnrr_back.sv
hdl/nearest_neighbor_raster_resampler.sv
hdl/nnrr_chk.sv
dv/nearest_neighbor_raster_resampler_tb.sv
